/* sv/lcdts_pkg.sv */
package lcdts_pkg;

   // Frame geometry in dots and lines
   localparam logic [8:0] DOTS_PER_LINE    = 9'd456;
   localparam logic [7:0] VISIBLE_LINES    = 8'd144;
   localparam logic [7:0] TOTAL_LINES      = 8'd154;
   localparam logic [8:0] DRAW_START_DOT   = 9'd80;
   localparam logic [8:0] HBLANK_START_DOT = 9'd252;

   localparam int unsigned PLAIN_COUNT = 7;
   localparam int unsigned PLAIN_IDX_W = 3;

   // LCDC and STAT bit positions
   localparam int unsigned LCDC_ENABLE_BIT = 7;
   localparam int unsigned STAT_WRITTEN_BIT = 7;
   localparam int unsigned STAT_LYC_IE_BIT = 6;
   localparam int unsigned STAT_OAM_IE_BIT = 5;
   localparam int unsigned STAT_VBL_IE_BIT = 4;
   localparam int unsigned STAT_HBL_IE_BIT = 3;
   localparam int unsigned STAT_LYC_FLAG_BIT = 2;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      REG_LCDC = 4'd0,
      REG_STAT = 4'd1,
      REG_SCY  = 4'd2,
      REG_SCX  = 4'd3,
      REG_LY   = 4'd4,
      REG_LYC  = 4'd5,
      REG_BGP  = 4'd6,
      REG_OBP0 = 4'd7,
      REG_OBP1 = 4'd8,
      REG_WY   = 4'd9,
      REG_WX   = 4'd10
   } reg_sel_type;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [3:0]  reg_select;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        vblank_irq;
      logic        stat_irq;
      mode_type    current_mode;
      logic [7:0]  current_line;
   } rsp_type;

   typedef struct packed {
      logic                   hit;
      logic [PLAIN_IDX_W-1:0] idx;
   } plain_slot_type;

   // Combined STAT interrupt line for the given STAT bits [7:2] and mode
   function automatic logic stat_level(input logic [7:2] stat_hi, input mode_type mode);
      logic lvl;
      lvl = ((mode == MODE_HBLANK) && stat_hi[STAT_HBL_IE_BIT]) ||
            ((mode == MODE_VBLANK) && stat_hi[STAT_VBL_IE_BIT]) ||
            ((mode == MODE_OAM)    && stat_hi[STAT_OAM_IE_BIT]) ||
            (stat_hi[STAT_LYC_FLAG_BIT] && stat_hi[STAT_LYC_IE_BIT]);
      return lvl;
   endfunction

   // Map a register select onto the plain register file
   function automatic plain_slot_type plain_slot(input logic [3:0] sel);
      plain_slot_type s;
      s.hit = 1'b1;
      case (sel)
         REG_SCY:  s.idx = 3'd0;
         REG_SCX:  s.idx = 3'd1;
         REG_BGP:  s.idx = 3'd2;
         REG_OBP0: s.idx = 3'd3;
         REG_OBP1: s.idx = 3'd4;
         REG_WY:   s.idx = 3'd5;
         REG_WX:   s.idx = 3'd6;
         default: begin
            s.hit = 1'b0;
            s.idx = 3'd0;
         end
      endcase
      return s;
   endfunction

endpackage

/* sv/lcdts_in_stage.sv */
module lcdts_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  lcdts_pkg::req_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output lcdts_pkg::req_type item
);

   logic              valid_ff, valid_in;
   lcdts_pkg::req_type item_ff;
   logic              take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/lcdts_core.sv */
module lcdts_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lcdts_pkg::req_type item,
   output lcdts_pkg::rsp_type result
);

   logic [7:0]               ctrl_ff, ctrl_in;
   logic [7:2]               stat_ff, stat_in;
   logic [7:0]               lyc_ff, lyc_in;
   logic [7:0]               line_ff, line_in;
   lcdts_pkg::mode_type      mode_ff, mode_in;
   logic [8:0]               dl_ff, dl_in;
   logic [8:0]               dm_ff, dm_in;
   logic                     lvl_ff, lvl_in;
   logic [7:0]               plain_ff [lcdts_pkg::PLAIN_COUNT];

   lcdts_pkg::plain_slot_type slot;
   logic                     plain_we;
   logic [8:0]               next_line;
   logic                     lvl_now;
   logic                     lcd_on;
   logic [7:0]               rd;
   logic                     vb;
   logic                     se;

   assign slot   = lcdts_pkg::plain_slot(item.reg_select);
   assign lcd_on = ctrl_ff[lcdts_pkg::LCDC_ENABLE_BIT];

   always_comb begin
      ctrl_in   = ctrl_ff;
      stat_in   = stat_ff;
      lyc_in    = lyc_ff;
      line_in   = line_ff;
      mode_in   = mode_ff;
      dl_in     = dl_ff;
      dm_in     = dm_ff;
      lvl_in    = lvl_ff;
      rd        = 8'd0;
      vb        = 1'b0;
      se        = 1'b0;
      plain_we  = 1'b0;
      next_line = {1'b0, line_ff} + 9'd1;
      lvl_now   = 1'b0;
      case (item.opcode)
         lcdts_pkg::OP_TICK: begin
            if (lcd_on) begin
               dl_in = dl_ff + 9'd1;
               dm_in = dm_ff + 9'd1;
               if (line_ff < lcdts_pkg::VISIBLE_LINES) begin
                  if (dl_in == lcdts_pkg::DRAW_START_DOT) begin
                     if (mode_in != lcdts_pkg::MODE_DRAW) begin
                        mode_in = lcdts_pkg::MODE_DRAW;
                        lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                        se      = se || (!lvl_in && lvl_now);
                        lvl_in  = lvl_now;
                     end
                     dm_in = 9'd0;
                  end
                  if (dl_in == lcdts_pkg::HBLANK_START_DOT) begin
                     if (mode_in != lcdts_pkg::MODE_HBLANK) begin
                        mode_in = lcdts_pkg::MODE_HBLANK;
                        lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                        se      = se || (!lvl_in && lvl_now);
                        lvl_in  = lvl_now;
                     end
                     dm_in = 9'd0;
                  end
                  if (dl_in == lcdts_pkg::DOTS_PER_LINE) begin
                     dm_in   = 9'd0;
                     dl_in   = 9'd0;
                     line_in = next_line[7:0];
                     if (line_in == lcdts_pkg::VISIBLE_LINES) begin
                        vb = 1'b1;
                        if (mode_in != lcdts_pkg::MODE_VBLANK) begin
                           mode_in = lcdts_pkg::MODE_VBLANK;
                           lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                           se      = se || (!lvl_in && lvl_now);
                           lvl_in  = lvl_now;
                        end
                     end else if (mode_in != lcdts_pkg::MODE_OAM) begin
                        mode_in = lcdts_pkg::MODE_OAM;
                        lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                        se      = se || (!lvl_in && lvl_now);
                        lvl_in  = lvl_now;
                     end
                     // refresh the coincidence flag
                     stat_in[lcdts_pkg::STAT_LYC_FLAG_BIT] = (lyc_in == line_in);
                     lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                     se      = se || (!lvl_in && lvl_now);
                     lvl_in  = lvl_now;
                  end
               end else if (dm_in == lcdts_pkg::DOTS_PER_LINE) begin
                  dm_in = 9'd0;
                  dl_in = 9'd0;
                  if ((next_line >= {1'b0, lcdts_pkg::TOTAL_LINES}) || next_line[8]) begin
                     line_in = 8'd0;
                     if (mode_in != lcdts_pkg::MODE_OAM) begin
                        mode_in = lcdts_pkg::MODE_OAM;
                        lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                        se      = se || (!lvl_in && lvl_now);
                        lvl_in  = lvl_now;
                     end
                  end else begin
                     line_in = next_line[7:0];
                  end
                  stat_in[lcdts_pkg::STAT_LYC_FLAG_BIT] = (lyc_in == line_in);
                  lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                  se      = se || (!lvl_in && lvl_now);
                  lvl_in  = lvl_now;
               end
            end
         end
         lcdts_pkg::OP_WRITE: begin
            case (item.reg_select)
               lcdts_pkg::REG_LCDC: begin
                  ctrl_in = item.write_data;
                  if (!lcd_on && item.write_data[lcdts_pkg::LCDC_ENABLE_BIT]) begin
                     stat_in[lcdts_pkg::STAT_LYC_FLAG_BIT] = (lyc_in == line_in);
                     lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                     se      = !lvl_in && lvl_now;
                     lvl_in  = lvl_now;
                  end
                  if (lcd_on && !item.write_data[lcdts_pkg::LCDC_ENABLE_BIT]) begin
                     // display off: clear position, keep flag and line level
                     line_in = 8'd0;
                     mode_in = lcdts_pkg::MODE_HBLANK;
                     dl_in   = 9'd0;
                     dm_in   = 9'd0;
                  end
               end
               lcdts_pkg::REG_STAT: begin
                  stat_in = {1'b1, item.write_data[6:3], (lyc_ff == line_ff)};
                  lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                  se      = !lvl_in && lvl_now;
                  lvl_in  = lvl_now;
               end
               lcdts_pkg::REG_LYC: begin
                  lyc_in = item.write_data;
                  if (lcd_on) begin
                     stat_in[lcdts_pkg::STAT_LYC_FLAG_BIT] = (lyc_in == line_in);
                     lvl_now = lcdts_pkg::stat_level(stat_in, mode_in);
                     se      = !lvl_in && lvl_now;
                     lvl_in  = lvl_now;
                  end
               end
               default: begin
                  plain_we = slot.hit;
               end
            endcase
         end
         lcdts_pkg::OP_READ: begin
            case (item.reg_select)
               lcdts_pkg::REG_LCDC: rd = ctrl_ff;
               lcdts_pkg::REG_STAT: rd = {stat_ff, (lcd_on ? mode_ff : lcdts_pkg::MODE_HBLANK)};
               lcdts_pkg::REG_LY:   rd = line_ff;
               lcdts_pkg::REG_LYC:  rd = lyc_ff;
               default:             rd = slot.hit ? plain_ff[slot.idx] : 8'd0;
            endcase
         end
         default: begin
            rd = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= 8'd0;
         stat_ff <= 6'd0;
         lyc_ff  <= 8'd0;
         line_ff <= 8'd0;
         mode_ff <= lcdts_pkg::MODE_HBLANK;
         dl_ff   <= 9'd0;
         dm_ff   <= 9'd0;
         lvl_ff  <= 1'b0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
         stat_ff <= stat_in;
         lyc_ff  <= lyc_in;
         line_ff <= line_in;
         mode_ff <= mode_in;
         dl_ff   <= dl_in;
         dm_ff   <= dm_in;
         lvl_ff  <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lcdts_pkg::PLAIN_COUNT; i++) begin
            plain_ff[i] <= 8'd0;
         end
      end else if (advance && plain_we) begin
         plain_ff[slot.idx] <= item.write_data;
      end
   end

   always_comb begin
      result.read_data    = rd;
      result.vblank_irq   = vb;
      result.stat_irq     = se;
      result.current_mode = mode_in;
      result.current_line = line_in;
   end

endmodule

/* sv/lcdts_out_stage.sv */
module lcdts_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lcdts_pkg::rsp_type result,
   output logic               out_load,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lcdts_pkg::rsp_type rsp_item
);

   logic               valid_ff, valid_in;
   lcdts_pkg::rsp_type rsp_ff;

   // result register frees up when empty or when its transaction completes
   assign out_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* sv/lcd_timing_stat_irq_unit_top.sv */
// LCD timing and STAT interrupt unit. Each request transaction is a dot tick,
// a register write, a register read or a no-op (opcode in req_tuser); every
// request yields exactly one response transaction carrying the read byte, the
// VBlank and STAT interrupt pulses, and the mode and line after that request.
// The unit takes one request per clock while rsp_tready is high: a request is
// held in the input register, is applied to the timing state in a single pass
// of counter and compare logic, and appears in the result register, so the
// sustained rate is one transaction per cycle, limited only by rsp_tready.
// While a response waits, the next request is still accepted and held in the
// input register. Writes to LY and to unused selects are dropped; reads of
// unused selects return zero.
module lcd_timing_stat_irq_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_data
   input  logic [5:0]  req_tuser,   // [1:0] opcode, [5:2] reg_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] vblank_irq, [9] stat_irq, [11:10] current_mode,
   // [19:12] current_line, [23:20] zero
   output logic [23:0] rsp_tdata
);

   lcdts_pkg::req_type req_item;
   lcdts_pkg::req_type item;
   lcdts_pkg::rsp_type result;
   lcdts_pkg::rsp_type rsp_item;
   logic               item_valid;
   logic               out_load;
   logic               advance;

   // unpack the request transaction
   always_comb begin
      req_item.opcode     = lcdts_pkg::opcode_type'(req_tuser[1:0]);
      req_item.reg_select = req_tuser[5:2];
      req_item.write_data = req_tdata;
   end

   // move the held request into the result register; state updates here
   assign advance = item_valid && out_load;

   lcdts_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lcdts_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   lcdts_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .out_load   (out_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // pack the response transaction
   assign rsp_tdata = {4'd0, rsp_item.current_line, rsp_item.current_mode,
                       rsp_item.stat_irq, rsp_item.vblank_irq, rsp_item.read_data};

endmodule
